// ===== sv/stt_pkg.sv =====
package stt_pkg;

    localparam int unsigned CODE_W   = 21;
    localparam int unsigned BYTES_W  = 3;
    localparam int unsigned KIND_W   = 3;
    localparam int unsigned LINE_W   = 24;
    localparam int unsigned COL_W    = 16;
    localparam int unsigned OFFSET_W = 32;
    localparam int unsigned LENGTH_W = 16;
    localparam int unsigned VALUE_W  = 63;

    // Default depth of the token queue; a power of two, at least 2.
    localparam int unsigned STT_FIFO_DEPTH = 4;

    localparam logic [KIND_W-1:0] KIND_END     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_IDENT   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_INTEGER = 3'd2;
    localparam logic [KIND_W-1:0] KIND_PUNCT   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN = 3'd4;

    localparam logic [CODE_W-1:0] CHAR_NUL     = 21'h00;
    localparam logic [CODE_W-1:0] CHAR_NEWLINE = 21'h0A;
    localparam logic [CODE_W-1:0] CHAR_HASH    = 21'h23;
    localparam logic [CODE_W-1:0] CHAR_ZERO    = 21'h30;
    localparam logic [CODE_W-1:0] CHAR_UNDER   = 21'h5F;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_INT,
        MODE_IDENT,
        MODE_COMMENT
    } scan_mode_t;

    typedef struct packed {
        logic [CODE_W-1:0]  code_point;
        logic [BYTES_W-1:0] byte_count;
    } in_item_t;

    typedef struct packed {
        logic [KIND_W-1:0]   token_kind;
        logic [LINE_W-1:0]   token_line;
        logic [COL_W-1:0]    token_column;
        logic [OFFSET_W-1:0] ident_offset;
        logic [LENGTH_W-1:0] ident_length;
        logic [VALUE_W-1:0]  int_value;
        logic                int_overflow;
        logic [CODE_W-1:0]   char_code;
        logic                last_of_run;
    } token_t;

    function automatic logic is_digit(input logic [CODE_W-1:0] c);
        return (c >= 21'h30) && (c <= 21'h39);
    endfunction

    function automatic logic is_letter(input logic [CODE_W-1:0] c);
        return ((c >= 21'h61) && (c <= 21'h7A)) || ((c >= 21'h41) && (c <= 21'h5A));
    endfunction

    function automatic logic is_space(input logic [CODE_W-1:0] c);
        return (c == 21'h20) || ((c >= 21'h09) && (c <= 21'h0D));
    endfunction

    function automatic logic is_punct(input logic [CODE_W-1:0] c);
        return (c >= 21'h21) && (c <= 21'h7E) && !is_digit(c) && !is_letter(c);
    endfunction

endpackage

// ===== sv/source_text_tokenizer.sv =====
// Channel   Direction  Ports                       Carries
// input     in         s_valid, s_ready, s_item    one code point and its UTF-8 byte count
// result    out        m_valid, m_ready, m_item    one token, last_of_run on its final one
//
// An accepted item is held in the input register and scanned from it once the queue has room;
// its zero, one or two tokens enter the token queue at the edge that ends the scan cycle, and the
// first token is taken from the queue. Items are taken every cycle while the queue has two
// free entries, so one-token items stream at one per cycle; two-token items are held to the
// one-token-per-cycle result port. Synchronous reset empties the input register and queue
// and restarts at line 1, column 0, byte 0; an m_ready stall fills the queue, then drops s_ready.
module source_text_tokenizer #(
    // Depth of the token queue: a power of two, at least 2.
    parameter int unsigned FIFO_DEPTH = stt_pkg::STT_FIFO_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  stt_pkg::in_item_t s_item,
    output logic              m_valid,
    input  logic              m_ready,
    output stt_pkg::token_t   m_item
);

    // Input register: holds one item until the token queue has room for it to be scanned.
    logic              in_valid_reg, in_valid_next;
    stt_pkg::in_item_t in_item_reg;

    logic              queue_room;
    logic              step;
    stt_pkg::token_t   tok0, tok1;
    logic [1:0]        tok_count;
    logic [1:0]        push_count;

    // The scan fires only when the queue can take both possible tokens.
    assign step       = in_valid_reg && queue_room;
    assign s_ready    = !in_valid_reg || step;
    assign push_count = step ? tok_count : 2'd0;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    // Scanner state and token formation.
    stt_lexer u_lexer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .item      (in_item_reg),
        .tok0      (tok0),
        .tok1      (tok1),
        .tok_count (tok_count)
    );

    // Tokens wait here for the result channel.
    stt_token_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_token_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_count (push_count),
        .push_tok0  (tok0),
        .push_tok1  (tok1),
        .has_room   (queue_room),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item)
    );

endmodule

// ===== sv/stt_lexer.sv =====
module stt_lexer (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            step,
    input  stt_pkg::in_item_t item,
    output stt_pkg::token_t tok0,
    output stt_pkg::token_t tok1,
    output logic [1:0]      tok_count
);

    localparam logic [stt_pkg::VALUE_W-1:0] VALUE_MAX = '1;
    localparam int unsigned WIDE_W = stt_pkg::VALUE_W + 4;

    stt_pkg::scan_mode_t mode_reg, mode_next;
    logic [stt_pkg::VALUE_W-1:0]  accum_reg, accum_next;
    logic                         ovf_reg, ovf_next;
    logic [stt_pkg::OFFSET_W-1:0] start_offset_reg, start_offset_next;
    logic [stt_pkg::LENGTH_W-1:0] run_length_reg, run_length_next;
    logic [stt_pkg::LINE_W-1:0]   start_line_reg, start_line_next;
    logic [stt_pkg::COL_W-1:0]    start_column_reg, start_column_next;
    logic [stt_pkg::LINE_W-1:0]   line_reg, line_next;
    logic [stt_pkg::COL_W-1:0]    column_reg, column_next;
    logic [stt_pkg::OFFSET_W-1:0] position_reg, position_next;

    logic [stt_pkg::CODE_W-1:0]   c;
    logic [stt_pkg::COL_W-1:0]    col;
    logic [WIDE_W-1:0]            wide;
    logic [stt_pkg::LENGTH_W:0]   len_sum;
    logic                         ident_char;
    logic                         run_idle;
    logic                         have_a, have_b;
    stt_pkg::token_t              tok_a, tok_b;

    always_comb begin
        c          = item.code_point;
        col        = (column_reg != '1) ? column_reg + 1'b1 : column_reg;
        ident_char = stt_pkg::is_letter(c) || stt_pkg::is_digit(c) || (c == stt_pkg::CHAR_UNDER);
        // Times ten as two shifted adds, plus the new digit.
        wide    = ({4'b0, accum_reg} << 3) + ({4'b0, accum_reg} << 1)
                  + WIDE_W'(c - stt_pkg::CHAR_ZERO);
        len_sum = {1'b0, run_length_reg} + (stt_pkg::LENGTH_W + 1)'(item.byte_count);

        mode_next         = mode_reg;
        accum_next        = accum_reg;
        ovf_next          = ovf_reg;
        start_offset_next = start_offset_reg;
        run_length_next   = run_length_reg;
        start_line_next   = start_line_reg;
        start_column_next = start_column_reg;
        line_next         = line_reg;
        column_next       = col;
        position_next     = position_reg + stt_pkg::OFFSET_W'(item.byte_count);

        tok_a    = '0;
        tok_b    = '0;
        have_a   = 1'b0;
        have_b   = 1'b0;
        run_idle = 1'b0;

        unique case (mode_reg)
            stt_pkg::MODE_INT: begin
                if (stt_pkg::is_digit(c)) begin
                    if (ovf_reg || (|wide[WIDE_W-1:stt_pkg::VALUE_W])) begin
                        accum_next = VALUE_MAX;
                        ovf_next   = 1'b1;
                    end else begin
                        accum_next = wide[stt_pkg::VALUE_W-1:0];
                    end
                end else begin
                    have_a             = 1'b1;
                    tok_a.token_kind   = stt_pkg::KIND_INTEGER;
                    tok_a.token_line   = start_line_reg;
                    tok_a.token_column = start_column_reg;
                    tok_a.int_value    = accum_reg;
                    tok_a.int_overflow = ovf_reg;
                    mode_next          = stt_pkg::MODE_IDLE;
                    run_idle           = 1'b1;
                end
            end
            stt_pkg::MODE_IDENT: begin
                if (ident_char) begin
                    run_length_next = len_sum[stt_pkg::LENGTH_W] ? '1
                                      : len_sum[stt_pkg::LENGTH_W-1:0];
                end else begin
                    have_a             = 1'b1;
                    tok_a.token_kind   = stt_pkg::KIND_IDENT;
                    tok_a.token_line   = start_line_reg;
                    tok_a.token_column = start_column_reg;
                    tok_a.ident_offset = start_offset_reg;
                    tok_a.ident_length = run_length_reg;
                    mode_next          = stt_pkg::MODE_IDLE;
                    run_idle           = 1'b1;
                end
            end
            stt_pkg::MODE_COMMENT: begin
                if ((c == stt_pkg::CHAR_NEWLINE) || (c == stt_pkg::CHAR_NUL)) begin
                    mode_next = stt_pkg::MODE_IDLE;
                    run_idle  = 1'b1;
                end
            end
            default: begin
                run_idle = 1'b1;
            end
        endcase

        if (run_idle) begin
            tok_b.token_line   = line_reg;
            tok_b.token_column = col;
            priority if (c == stt_pkg::CHAR_NUL) begin
                have_b           = 1'b1;
                tok_b.token_kind = stt_pkg::KIND_END;
            end else if (c == stt_pkg::CHAR_NEWLINE) begin
                line_next   = (line_reg != '1) ? line_reg + 1'b1 : line_reg;
                column_next = '0;
            end else if (stt_pkg::is_space(c)) begin
                // Whitespace only moves the counters.
            end else if (c == stt_pkg::CHAR_HASH) begin
                mode_next = stt_pkg::MODE_COMMENT;
            end else if (stt_pkg::is_digit(c)) begin
                mode_next         = stt_pkg::MODE_INT;
                accum_next        = stt_pkg::VALUE_W'(c - stt_pkg::CHAR_ZERO);
                ovf_next          = 1'b0;
                start_line_next   = line_reg;
                start_column_next = col;
            end else if (stt_pkg::is_letter(c)) begin
                mode_next         = stt_pkg::MODE_IDENT;
                start_offset_next = position_reg;
                run_length_next   = stt_pkg::LENGTH_W'(item.byte_count);
                start_line_next   = line_reg;
                start_column_next = col;
            end else if (stt_pkg::is_punct(c)) begin
                have_b           = 1'b1;
                tok_b.token_kind = stt_pkg::KIND_PUNCT;
                tok_b.char_code  = c;
            end else begin
                have_b           = 1'b1;
                tok_b.token_kind = stt_pkg::KIND_UNKNOWN;
                tok_b.char_code  = c;
            end
        end

        tok0             = have_a ? tok_a : tok_b;
        tok0.last_of_run = !(have_a && have_b);
        tok1             = tok_b;
        tok1.last_of_run = 1'b1;
        tok_count        = {1'b0, have_a} + {1'b0, have_b};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= stt_pkg::MODE_IDLE;
            accum_reg        <= '0;
            ovf_reg          <= 1'b0;
            start_offset_reg <= '0;
            run_length_reg   <= '0;
            start_line_reg   <= stt_pkg::LINE_W'(1);
            start_column_reg <= '0;
            line_reg         <= stt_pkg::LINE_W'(1);
            column_reg       <= '0;
            position_reg     <= '0;
        end else if (step) begin
            mode_reg         <= mode_next;
            accum_reg        <= accum_next;
            ovf_reg          <= ovf_next;
            start_offset_reg <= start_offset_next;
            run_length_reg   <= run_length_next;
            start_line_reg   <= start_line_next;
            start_column_reg <= start_column_next;
            line_reg         <= line_next;
            column_reg       <= column_next;
            position_reg     <= position_next;
        end
    end

endmodule

// ===== sv/stt_token_fifo.sv =====
module stt_token_fifo #(
    parameter int unsigned DEPTH = stt_pkg::STT_FIFO_DEPTH
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [1:0]      push_count,
    input  stt_pkg::token_t push_tok0,
    input  stt_pkg::token_t push_tok1,
    output logic            has_room,
    output logic            m_valid,
    input  logic            m_ready,
    output stt_pkg::token_t m_item
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    stt_pkg::token_t   entries_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [PTR_W-1:0]  wr_ptr_plus1;
    logic              pop;

    assign pop          = m_valid && m_ready;
    assign m_valid      = (count_reg != '0);
    assign m_item       = entries_reg[rd_ptr_reg];
    // Two free entries are needed, since one item can leave two tokens.
    assign has_room     = (count_reg <= CNT_W'(DEPTH - 2));
    assign wr_ptr_plus1 = wr_ptr_reg + PTR_W'(1);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push_count) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push_count != 2'd0) begin
            entries_reg[wr_ptr_reg] <= push_tok0;
        end
        if (push_count == 2'd2) begin
            entries_reg[wr_ptr_plus1] <= push_tok1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
